/* rtl/core/round_robin_slice_scheduler_core_assert.svh */
// assertion macros for the scheduler core
`ifndef ROUND_ROBIN_SLICE_SCHEDULER_CORE_ASSERT_SVH
`define ROUND_ROBIN_SLICE_SCHEDULER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RRSS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rrss assertion failed");
`define RRSS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rrss assertion failed");
`else
`define RRSS_ASSERT(lbl, clk, rst_n, prop)
`define RRSS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/core/rrss_pkg.sv */
// package for the round-robin slice scheduler: widths, codes and types
`timescale 1ns / 1ps
`default_nettype none
package rrss_pkg;

    localparam int MAX_JOBS_DEF = 16;
    localparam int CMD_W        = 2;
    localparam int ID_W         = 8;
    localparam int UNITS_W      = 16;
    localparam int ELAPSED_W    = 32;
    localparam int STATUS_W     = 3;
    localparam int WORD_W       = ID_W + UNITS_W;

    localparam logic [UNITS_W-1:0] QUANTUM_RESET = UNITS_W'(3);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_SLICE = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_LOADED   = 3'd0,
        ST_FULL     = 3'd1,
        ST_ISSUED   = 3'd2,
        ST_ALL_DONE = 3'd3,
        ST_CLEARED  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CALC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [UNITS_W-1:0]   units;
        logic                 fin;
        logic [UNITS_W-1:0]   rem_next;
        logic [ELAPSED_W-1:0] elapsed;
    } t_slice_res;

endpackage
`default_nettype wire

/* rtl/core/rrss_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module rrss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/core/rrss_slice_calc.sv */
// slice arithmetic: units run, completion, new remainder, saturating elapsed time
`timescale 1ns / 1ps
`default_nettype none
module rrss_slice_calc (
    input  wire logic [rrss_pkg::UNITS_W-1:0]   i_rem,
    input  wire logic [rrss_pkg::UNITS_W-1:0]   i_quantum,
    input  wire logic [rrss_pkg::ELAPSED_W-1:0] i_elapsed,
    output rrss_pkg::t_slice_res                o_res
);
    import rrss_pkg::*;

    logic                 fin;
    logic [UNITS_W-1:0]   units;
    logic [ELAPSED_W:0]   sum;

    always_comb begin
        fin   = (i_rem <= i_quantum);
        units = fin ? i_rem : i_quantum;
        sum   = {1'b0, i_elapsed} + (ELAPSED_W + 1)'(units);
        o_res.units    = units;
        o_res.fin      = fin;
        o_res.rem_next = fin ? '0 : (i_rem - i_quantum);
        o_res.elapsed  = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
    end

endmodule
`default_nettype wire

/* rtl/core/round_robin_slice_scheduler_core.sv */
// round-robin time-slice scheduler core: job table, slot scan and slice issue
// channels: command items on i_in_valid/o_in_ready (command, job id, burst),
//   results on o_out_valid/i_out_ready (status, job id, units, finished,
//   elapsed), quantum register on i_cfg_valid/o_cfg_ready/i_cfg_data
// every command except the unused code gives one result; the unused code is
//   taken and dropped
// one item at a time: load and clear go through the done state to the output
//   register; a slice scans the finished flags one slot per cycle from the
//   round-robin pointer, at most the job count and so MAX_JOBS slots; if it
//   finds an unfinished job, the calc state uses the registered read of the
//   job ram and the result goes through done, else done gives all-done
// the job ram holds id and remaining burst; finished flags are flip-flops
// a new item is taken while the previous result waits in the output register;
//   if the receiver stalls, the block holds its next result and waits
// reset (synchronous, active low) empties the table, zeroes elapsed time and
//   sets the quantum to 3; ram contents are left as they are
`timescale 1ns / 1ps
`default_nettype none
`include "round_robin_slice_scheduler_core_assert.svh"
module round_robin_slice_scheduler_core #(
    parameter int MAX_JOBS = rrss_pkg::MAX_JOBS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [rrss_pkg::CMD_W-1:0]       i_command,
    input  wire logic [rrss_pkg::ID_W-1:0]        i_job_id,
    input  wire logic [rrss_pkg::UNITS_W-1:0]     i_burst_time,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic      [rrss_pkg::STATUS_W-1:0]    o_status,
    output logic      [rrss_pkg::ID_W-1:0]        o_slice_job_id,
    output logic      [rrss_pkg::UNITS_W-1:0]     o_slice_units,
    output logic                                  o_job_finished,
    output logic      [rrss_pkg::ELAPSED_W-1:0]   o_elapsed_time,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [rrss_pkg::UNITS_W-1:0]     i_cfg_data
);
    import rrss_pkg::*;

    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    t_state               r_state, n_state;
    logic [UNITS_W-1:0]   r_quantum, n_quantum;
    logic [MAX_JOBS-1:0]  r_fin, n_fin;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [IDX_W-1:0]     r_ptr, n_ptr;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [IDX_W-1:0]     r_slot, n_slot;
    logic [CNT_W-1:0]     r_k, n_k;
    logic                 r_out_valid, n_out_valid;

    t_status              r_res_status, n_res_status;
    logic [ID_W-1:0]      r_res_id, n_res_id;
    logic [UNITS_W-1:0]   r_res_units, n_res_units;
    logic                 r_res_fin, n_res_fin;
    t_status              r_out_status, n_out_status;
    logic [ID_W-1:0]      r_out_id, n_out_id;
    logic [UNITS_W-1:0]   r_out_units, n_out_units;
    logic                 r_out_fin, n_out_fin;
    logic [ELAPSED_W-1:0] r_out_elapsed, n_out_elapsed;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [WORD_W-1:0]    ram_rdata;
    logic [IDX_W-1:0]     slot_next;
    logic                 in_acc;
    t_slice_res           calc;

    rrss_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_JOBS),
        .AW    (IDX_W)
    ) u_job_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    rrss_slice_calc u_calc (
        .i_rem     (ram_rdata[UNITS_W-1:0]),
        .i_quantum (r_quantum),
        .i_elapsed (r_elapsed),
        .o_res     (calc)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign slot_next   = ((CNT_W'(r_slot) + CNT_W'(1)) >= r_count) ? '0
                                                                 : (r_slot + IDX_W'(1));

    always_comb begin
        n_state       = r_state;
        n_quantum     = (i_cfg_valid) ? i_cfg_data : r_quantum;
        n_fin         = r_fin;
        n_count       = r_count;
        n_ptr         = r_ptr;
        n_elapsed     = r_elapsed;
        n_slot        = r_slot;
        n_k           = r_k;
        n_out_valid   = r_out_valid;
        n_res_status  = r_res_status;
        n_res_id      = r_res_id;
        n_res_units   = r_res_units;
        n_res_fin     = r_res_fin;
        n_out_status  = r_out_status;
        n_out_id      = r_out_id;
        n_out_units   = r_out_units;
        n_out_fin     = r_out_fin;
        n_out_elapsed = r_out_elapsed;
        ram_we        = 1'b0;
        ram_waddr     = r_count[IDX_W-1:0];
        ram_wdata     = {i_job_id, i_burst_time};

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res_id    = '0;
                    n_res_units = '0;
                    n_res_fin   = 1'b0;
                    case (i_command)
                        CMD_LOAD: begin
                            if (r_count >= CNT_W'(MAX_JOBS)) begin
                                n_res_status = ST_FULL;
                            end else begin
                                ram_we                      = 1'b1;
                                n_fin[r_count[IDX_W-1:0]]   = 1'b0;
                                n_count                     = r_count + CNT_W'(1);
                                n_res_status                = ST_LOADED;
                            end
                            n_state = S_DONE;
                        end
                        CMD_SLICE: begin
                            n_slot  = (CNT_W'(r_ptr) >= r_count) ? '0 : r_ptr;
                            n_k     = '0;
                            n_state = S_SCAN;
                        end
                        CMD_CLEAR: begin
                            n_fin        = '0;
                            n_count      = '0;
                            n_ptr        = '0;
                            n_elapsed    = '0;
                            n_res_status = ST_CLEARED;
                            n_state      = S_DONE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                priority if (r_k == r_count) begin
                    n_res_status = ST_ALL_DONE;
                    n_state      = S_DONE;
                end else if (!r_fin[r_slot]) begin
                    n_state = S_CALC;
                end else begin
                    n_slot = slot_next;
                    n_k    = r_k + CNT_W'(1);
                end
            end
            S_CALC: begin
                ram_we          = 1'b1;
                ram_waddr       = r_slot;
                ram_wdata       = {ram_rdata[WORD_W-1:UNITS_W], calc.rem_next};
                n_fin[r_slot]   = calc.fin;
                n_elapsed       = calc.elapsed;
                n_ptr           = slot_next;
                n_res_status    = ST_ISSUED;
                n_res_id        = ram_rdata[WORD_W-1:UNITS_W];
                n_res_units     = calc.units;
                n_res_fin       = calc.fin;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_res_status;
                    n_out_id      = r_res_id;
                    n_out_units   = r_res_units;
                    n_out_fin     = r_res_fin;
                    n_out_elapsed = r_elapsed;
                    n_state       = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_quantum   <= QUANTUM_RESET;
            r_fin       <= '0;
            r_count     <= '0;
            r_ptr       <= '0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_quantum   <= n_quantum;
            r_fin       <= n_fin;
            r_count     <= n_count;
            r_ptr       <= n_ptr;
            r_elapsed   <= n_elapsed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot        <= n_slot;
        r_k           <= n_k;
        r_res_status  <= n_res_status;
        r_res_id      <= n_res_id;
        r_res_units   <= n_res_units;
        r_res_fin     <= n_res_fin;
        r_out_status  <= n_out_status;
        r_out_id      <= n_out_id;
        r_out_units   <= n_out_units;
        r_out_fin     <= n_out_fin;
        r_out_elapsed <= n_out_elapsed;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_slice_job_id = r_out_id;
    assign o_slice_units  = r_out_units;
    assign o_job_finished = r_out_fin;
    assign o_elapsed_time = r_out_elapsed;

    // table never grows past its depth
    `RRSS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(MAX_JOBS))
    // a slot is only served while it is unfinished
    `RRSS_ASSERT(a_calc_unfinished, i_clk, i_rst_n, (r_state == S_CALC) |-> !r_fin[r_slot])
    // scan visits at most job_count slots
    `RRSS_ASSERT(a_scan_bound, i_clk, i_rst_n, (r_state == S_SCAN) |-> (r_k <= r_count))
    // an issued slice never runs longer than the quantum
    `RRSS_ASSERT(a_units_le_quantum, i_clk, i_rst_n,
        (r_state == S_CALC) |=> (r_res_units <= r_quantum))
    // leaving reset puts the block in idle with no result pending
    `RRSS_ASSERT_ALWAYS(a_reset_idle, i_clk,
        !i_rst_n |=> (r_state == S_IDLE) && !r_out_valid)

endmodule
`default_nettype wire
